>>> hw/rtl/ffa_pkg.sv
package ffa_pkg;
	localparam int HEAP_BYTES      = 256;
	localparam int FREE_LIST_DEPTH = 64;
	localparam int WORD_BYTES      = 4;
	localparam int HEAP_WORDS      = HEAP_BYTES / WORD_BYTES;
	localparam int SPLIT_MIN       = WORD_BYTES * 2;
	localparam int LIST_AW         = $clog2(FREE_LIST_DEPTH);
	localparam int HDR_AW          = $clog2(HEAP_WORDS);
	localparam int CNT_W           = LIST_AW + 1;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_RESET = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NO_FIT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_HD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_SPLIT,
		S_SPLIT_WR,
		S_FREE_HD,
		S_FREE_UPD,
		S_SUM_RD,
		S_SUM_HD,
		S_SUM_ACC,
		S_DONE
	} state_t;

	function automatic logic [HDR_AW-1:0] hdr_index(input logic [7:0] off);
		hdr_index = HDR_AW'(off >> 2);
	endfunction
endpackage

>>> hw/rtl/ffa_ram.sv
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/first_fit_free_list_allocator.sv
// Reset request and no-op go straight to the result; free appends the block, then walks
// the list summing free bytes (free-total walk); a free on a full list returns ST_FULL.
// Allocate scans entries for a first fit, compacts the entries behind the hit, and
// on a split writes both headers and lists the remainder block.
// Throughput: one transaction in flight; the next is taken once the result leaves.
// Reset: arst_n clears control; a 1-cycle init rewrites header word 0 and entry 0.
module first_fit_free_list_allocator
	import ffa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] request_bytes,
	input  logic [7:0] payload_address,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [7:0] result_address,
	output logic [6:0] live_objects,
	output logic [8:0] free_bytes
);
	state_t state_q, state_d;

	// list memory
	logic               l_we;
	logic [LIST_AW-1:0] l_wa, l_ra;
	logic [7:0]         l_wd, l_rd;
	// header memory
	logic               h_we;
	logic [HDR_AW-1:0]  h_wa, h_ra;
	logic [7:0]         h_wd, h_rd;

	ffa_ram #(.WIDTH(8), .DEPTH(FREE_LIST_DEPTH)) u_list (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
	ffa_ram #(.WIDTH(8), .DEPTH(HEAP_WORDS)) u_hdr (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [6:0]       tally_q, tally_d;
	logic [8:0]       touched_q, touched_d;
	logic [8:0]       total_q, total_d;
	logic [8:0]       sum_q, sum_d;
	logic [8:0]       need_q, need_d;     // rounded size, up to 256
	logic [7:0]       addr_q, addr_d;
	logic [7:0]       off_q, off_d;
	logic [7:0]       size_q, size_d;
	logic [1:0]       st_q, st_d;
	logic [7:0]       res_q, res_d;
	logic             init_q, init_d;

	logic [9:0] sum_next;
	logic [7:0] pay;
	logic [7:0] nxt;
	logic [9:0] tmark;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= CNT_W'(1);
			tally_q   <= '0;
			touched_q <= '0;
			total_q   <= 9'(HEAP_BYTES);
			init_q    <= 1'b1;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			tally_q   <= tally_d;
			touched_q <= touched_d;
			total_q   <= total_d;
			init_q    <= init_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		sum_q  <= sum_d;
		need_q <= need_d;
		addr_q <= addr_d;
		off_q  <= off_d;
		size_q <= size_d;
		st_q   <= st_d;
		res_q  <= res_d;
	end

	assign in_ready       = (state_q == S_IDLE) && !init_q;
	assign out_valid      = (state_q == S_DONE);
	assign status         = st_q;
	assign result_address = res_q;
	assign live_objects   = tally_q;
	assign free_bytes     = total_q;

	always_comb begin
		state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; tally_d = tally_q;
		touched_d = touched_q; total_d = total_q; sum_d = sum_q;
		need_d = need_q; addr_d = addr_q; off_d = off_q; size_d = size_q;
		st_d = st_q; res_d = res_q; init_d = 1'b0;
		l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = idx_q[LIST_AW-1:0];
		h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = hdr_index(off_q);
		pay      = off_q + 8'(WORD_BYTES);
		nxt      = pay + need_q[7:0];
		tmark    = 10'(pay) + 10'(need_q) + 10'(WORD_BYTES);
		sum_next = 10'(sum_q) + 10'(h_rd) + 10'(WORD_BYTES);

		unique case (state_q)
			S_IDLE: begin
				if (init_q) begin
					// rebuild the single whole-heap block
					h_we = 1'b1; h_wa = '0; h_wd = 8'(HEAP_BYTES - WORD_BYTES);
					l_we = 1'b1; l_wa = '0; l_wd = '0;
				end else if (in_valid) begin
					need_d = (9'(request_bytes) + 9'd3) & ~9'd3;
					addr_d = payload_address;
					off_d  = payload_address - 8'(WORD_BYTES);
					st_d   = ST_OK;
					res_d  = '0;
					idx_d  = '0;
					sum_d  = '0;
					unique case (req_type)
						REQ_ALLOC: state_d = S_SCAN_RD;
						REQ_FREE: begin
							if (cnt_q >= CNT_W'(FREE_LIST_DEPTH)) begin
								st_d = ST_FULL; state_d = S_DONE;
							end else begin
								state_d = S_FREE_HD;
							end
						end
						REQ_RESET: begin
							h_we = 1'b1; h_wa = '0; h_wd = 8'(HEAP_BYTES - WORD_BYTES);
							l_we = 1'b1; l_wa = '0; l_wd = '0;
							cnt_d = CNT_W'(1); tally_d = '0;
							state_d = S_DONE;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN_RD: begin
				if (idx_q >= cnt_q) begin
					st_d = ST_NO_FIT; state_d = S_DONE;
				end else begin
					state_d = S_SCAN_HD;
				end
			end
			S_SCAN_HD: begin
				off_d = l_rd;
				h_ra = hdr_index(l_rd);
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (9'(h_rd) < need_q) begin
					idx_d = idx_q + 1'b1; state_d = S_SCAN_RD;
				end else begin
					size_d = h_rd;
					l_ra = LIST_AW'(idx_q + 1'b1);
					state_d = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				// entry idx+1 read issued; data valid now if in range
				if (idx_q + 1'b1 < cnt_q) begin
					l_we = 1'b1; l_wa = idx_q[LIST_AW-1:0]; l_wd = l_rd;
					idx_d = idx_q + 1'b1;
					l_ra = LIST_AW'(idx_q + 2'd2);
					state_d = S_SHIFT_WR;
				end else begin
					cnt_d = cnt_q - 1'b1;
					state_d = S_SPLIT;
				end
			end
			S_SHIFT_WR: begin
				// fetch the entry behind the new idx
				l_ra = LIST_AW'(idx_q + 1'b1);
				state_d = S_SHIFT_RD;
			end
			S_SPLIT: begin
				state_d = S_DONE;
				if (10'(size_q) >= 10'(need_q) + 10'(SPLIT_MIN)) begin
					h_we = 1'b1; h_wa = hdr_index(off_q); h_wd = need_q[7:0];
					// remainder header written next cycle via addr_q
					addr_d = nxt;
					size_d = size_q - need_q[7:0] - 8'(WORD_BYTES);
					l_we = 1'b1; l_wa = cnt_q[LIST_AW-1:0]; l_wd = nxt;
					cnt_d = cnt_q + 1'b1;
					state_d = S_SPLIT_WR;
				end
				if (tally_q != 7'd127) tally_d = tally_q + 1'b1;
				if (touched_q < 9'(HEAP_BYTES))
					touched_d = (tmark > 10'd511) ? 9'd511 : tmark[8:0];
				res_d = pay;
			end
			S_SPLIT_WR: begin
				h_we = 1'b1; h_wa = hdr_index(addr_q); h_wd = size_q;
				state_d = S_DONE;
			end
			S_FREE_HD: begin
				state_d = S_FREE_UPD;
			end
			S_FREE_UPD: begin
				l_we = 1'b1; l_wa = cnt_q[LIST_AW-1:0]; l_wd = off_q;
				cnt_d = cnt_q + 1'b1;
				if ((9'(addr_q) + 9'(h_rd) <= touched_q) && tally_q != '0)
					tally_d = tally_q - 1'b1;
				state_d = S_SUM_RD;
			end
			S_SUM_RD: begin
				if (idx_q >= cnt_q) begin
					total_d = sum_q; state_d = S_DONE;
				end else begin
					state_d = S_SUM_HD;
				end
			end
			S_SUM_HD: begin
				h_ra = hdr_index(l_rd);
				state_d = S_SUM_ACC;
			end
			S_SUM_ACC: begin
				sum_d = (sum_next > 10'd511) ? 9'd511 : sum_next[8:0];
				idx_d = idx_q + 1'b1;
				state_d = S_SUM_RD;
			end
			S_DONE: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FREE_LIST_DEPTH))
		else $error("list count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_type == REQ_RESET) |=> (cnt_q == CNT_W'(1) && tally_q == '0))
		else $error("reset request did not rebuild heap");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NO_FIT) |-> (result_address == '0))
		else $error("failed allocate returned address");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped");
endmodule
